### hw/rtl/bnfa_pkg.sv
// Shared types and constants for the bitmap next-fit allocator.
// Used by bitmap_next_fit_allocator_core. No dependencies.
`default_nettype none

package bnfa_pkg;

    localparam int MAP_BYTES = 512;
    localparam int MAP_AW    = $clog2(MAP_BYTES);
    localparam int ENTRY_W   = 13;
    localparam int BYTE_W    = 8;
    localparam int BIT_W     = 3;

    localparam logic [BYTE_W-1:0]  FULL_BYTE   = 8'hFF;
    localparam logic [BYTE_W-1:0]  TOP_BIT     = 8'h80;
    localparam logic [ENTRY_W-1:0] LIMIT_RESET = 13'd4096;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_FREE_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUMBER_BASE = 2'd1;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

### hw/rtl/bnfa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bnfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### hw/rtl/bitmap_next_fit_allocator_core.sv
// Top level of the bitmap next-fit allocator: usage map RAM, scan sequencer,
// free count and hint. Depends on bnfa_pkg and bnfa_ram.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  request | in_valid, in_stall, cmd, entry_number     | in
//  result  | out_valid, out_stall, status,             | out
//          | granted_entry, free_remaining             |
//  config  | cfg_we, cfg_index, cfg_data               | in
//
// After reset the map RAM is cleared one byte a cycle, all MAP_BYTES (512)
// bytes, while in_stall is high. One request is in flight at a time.
// A free, or an allocate with a zero count, goes from IDLE straight to
// FINISH; any other allocate passes through SCAN, where the RAM read port
// checks one byte a cycle, up to one pass, before FINISH.
// A held result stalls only the final write-back of the following request.
`default_nettype none

module bitmap_next_fit_allocator_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              cmd,
    input  wire logic [bnfa_pkg::ENTRY_W-1:0]      entry_number,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   status,
    output logic      [bnfa_pkg::ENTRY_W-1:0]      granted_entry,
    output logic      [bnfa_pkg::ENTRY_W-1:0]      free_remaining,
    input  wire logic                              cfg_we,
    input  wire logic [bnfa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bnfa_pkg::ENTRY_W-1:0]      cfg_data
);

    localparam int AW = bnfa_pkg::MAP_AW;
    localparam int EW = bnfa_pkg::ENTRY_W;
    localparam int BW = bnfa_pkg::BYTE_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(bnfa_pkg::MAP_BYTES - 1);

    bnfa_pkg::state_t state_reg, state_next;

    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic [AW-1:0] scan_cnt_reg, scan_cnt_next;
    logic [AW-1:0] rd_addr_reg, rd_addr_next;
    logic [AW-1:0] chk_addr_reg, chk_addr_next;
    logic          cmd_reg, cmd_next;
    logic          skip_reg, skip_next;
    logic [bnfa_pkg::BIT_W-1:0] bit_reg, bit_next;

    logic [EW-1:0] limit_reg, limit_next;
    logic          base_reg, base_next;
    logic [EW-1:0] hint_reg, hint_next;
    logic [EW-1:0] count_reg, count_next;

    logic          out_valid_reg, out_valid_next;
    logic          status_reg, status_next;
    logic [EW-1:0] granted_reg, granted_next;
    logic [EW-1:0] remaining_reg, remaining_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [BW-1:0] ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [BW-1:0] ram_rdata;

    logic [EW-1:0] hint_off;
    logic [EW-1:0] free_off;
    logic [AW-1:0] start_pos;
    logic [AW-1:0] free_pos;
    logic          free_in_range;
    logic          byte_open;
    logic          scan_last;
    logic          slot_free;
    logic [bnfa_pkg::BIT_W-1:0] open_bit;
    logic [EW-1:0] alloc_entry;

    // First clear bit, most significant first.
    function automatic logic [bnfa_pkg::BIT_W-1:0] first_clear(input logic [BW-1:0] b);
        logic [bnfa_pkg::BIT_W-1:0] idx;
        logic                       hit;
        idx = '0;
        hit = 1'b0;
        for (int i = 0; i < BW; i++)
        begin
            if (!hit && !b[BW-1-i])
            begin
                idx = bnfa_pkg::BIT_W'(i);
                hit = 1'b1;
            end
        end
        return idx;
    endfunction

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
        return (a == LAST_ADDR) ? '0 : a + AW'(1);
    endfunction

    bnfa_ram #(
        .WIDTH(BW),
        .DEPTH(bnfa_pkg::MAP_BYTES)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign hint_off      = hint_reg - EW'(base_reg);
    assign free_off      = entry_number - EW'(base_reg);
    assign start_pos     = hint_off[AW+2:3];
    assign free_pos      = free_off[AW+2:3];
    assign free_in_range = 32'(free_off[EW-1:3]) < 32'(bnfa_pkg::MAP_BYTES);
    assign byte_open     = ram_rdata != bnfa_pkg::FULL_BYTE;
    assign scan_last     = scan_cnt_reg == LAST_ADDR;
    assign slot_free     = !out_valid_reg || !out_stall;
    assign open_bit      = first_clear(ram_rdata);
    assign alloc_entry   = EW'({chk_addr_reg, open_bit}) + EW'(base_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bnfa_pkg::ST_CLEAR:
            begin
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = bnfa_pkg::ST_IDLE;
                end
            end
            bnfa_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (cmd == bnfa_pkg::CMD_ALLOC && count_reg != '0)
                    begin
                        state_next = bnfa_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = bnfa_pkg::ST_FINISH;
                    end
                end
            end
            bnfa_pkg::ST_SCAN:
            begin
                if (byte_open || scan_last)
                begin
                    state_next = bnfa_pkg::ST_FINISH;
                end
            end
            bnfa_pkg::ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = bnfa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bnfa_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath, RAM control and outputs.
    always_comb
    begin
        clr_addr_next  = clr_addr_reg;
        scan_cnt_next  = scan_cnt_reg;
        rd_addr_next   = rd_addr_reg;
        chk_addr_next  = chk_addr_reg;
        cmd_next       = cmd_reg;
        skip_next      = skip_reg;
        bit_next       = bit_reg;
        limit_next     = limit_reg;
        base_next      = base_reg;
        hint_next      = hint_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        granted_next   = granted_reg;
        remaining_next = remaining_reg;
        ram_we         = 1'b0;
        ram_waddr      = chk_addr_reg;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = rd_addr_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            bnfa_pkg::ST_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + AW'(1);
            end
            bnfa_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next      = cmd;
                    scan_cnt_next = '0;
                    if (cmd == bnfa_pkg::CMD_ALLOC)
                    begin
                        skip_next = count_reg == '0;
                        if (count_reg != '0)
                        begin
                            ram_re        = 1'b1;
                            ram_raddr     = start_pos;
                            chk_addr_next = start_pos;
                            rd_addr_next  = wrap_inc(start_pos);
                        end
                    end
                    else
                    begin
                        skip_next = !free_in_range;
                        bit_next  = free_off[bnfa_pkg::BIT_W-1:0];
                        if (free_in_range)
                        begin
                            ram_re        = 1'b1;
                            ram_raddr     = free_pos;
                            chk_addr_next = free_pos;
                        end
                    end
                end
            end
            bnfa_pkg::ST_SCAN:
            begin
                // Hold the read data once an open byte turns up.
                if (byte_open)
                begin
                    skip_next = 1'b0;
                end
                else if (scan_last)
                begin
                    skip_next = 1'b1;
                end
                else
                begin
                    ram_re        = 1'b1;
                    ram_raddr     = rd_addr_reg;
                    chk_addr_next = rd_addr_reg;
                    rd_addr_next  = wrap_inc(rd_addr_reg);
                    scan_cnt_next = scan_cnt_reg + AW'(1);
                end
            end
            bnfa_pkg::ST_FINISH:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = bnfa_pkg::STATUS_OK;
                    granted_next   = '0;
                    remaining_next = count_reg;
                    if (cmd_reg == bnfa_pkg::CMD_ALLOC)
                    begin
                        if (skip_reg)
                        begin
                            status_next = bnfa_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            ram_we         = 1'b1;
                            ram_wdata      = ram_rdata | (bnfa_pkg::TOP_BIT >> open_bit);
                            granted_next   = alloc_entry;
                            hint_next      = alloc_entry;
                            count_next     = count_reg - EW'(1);
                            remaining_next = count_reg - EW'(1);
                        end
                    end
                    else if (!skip_reg)
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = ram_rdata & ~(bnfa_pkg::TOP_BIT >> bit_reg);
                        if (count_reg < limit_reg)
                        begin
                            count_next     = count_reg + EW'(1);
                            remaining_next = count_reg + EW'(1);
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (cfg_we)
        begin
            if (cfg_index == bnfa_pkg::REG_FREE_LIMIT)
            begin
                limit_next = cfg_data;
                count_next = cfg_data;
            end
            else if (cfg_index == bnfa_pkg::REG_NUMBER_BASE)
            begin
                base_next = cfg_data[0];
                hint_next = EW'(cfg_data[0]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bnfa_pkg::ST_CLEAR;
            clr_addr_reg  <= '0;
            limit_reg     <= bnfa_pkg::LIMIT_RESET;
            base_reg      <= 1'b0;
            hint_reg      <= '0;
            count_reg     <= bnfa_pkg::LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            limit_reg     <= limit_next;
            base_reg      <= base_next;
            hint_reg      <= hint_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_cnt_reg  <= scan_cnt_next;
        rd_addr_reg   <= rd_addr_next;
        chk_addr_reg  <= chk_addr_next;
        cmd_reg       <= cmd_next;
        skip_reg      <= skip_next;
        bit_reg       <= bit_next;
        status_reg    <= status_next;
        granted_reg   <= granted_next;
        remaining_reg <= remaining_next;
    end

    assign in_stall       = state_reg != bnfa_pkg::ST_IDLE;
    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign granted_entry  = granted_reg;
    assign free_remaining = remaining_reg;

endmodule

`default_nettype wire
